@@ rtl/hpq_pkg.sv @@
// ----------------------------------------------------------------------------
// hpq_pkg
// Types and codes used by the max-heap priority queue.
// ----------------------------------------------------------------------------
package hpq_pkg;

  // Operation carried by a request transaction
  typedef enum logic {
    MODE_INSERT  = 1'b0,
    MODE_EXTRACT = 1'b1
  } hpq_mode_e;

  // Completion code of a transaction
  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } hpq_status_e;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_IN_CHK,
    ST_IN_CMP,
    ST_EX_ROOT,
    ST_EX_LAST,
    ST_SD_LOAD,
    ST_SD_CHK,
    ST_SD_LEFT,
    ST_SD_RIGHT
  } hpq_state_e;

  localparam int unsigned ValueW = 32;
  localparam int unsigned CountW = 5;

  typedef struct packed {
    hpq_mode_e                mode;
    logic signed [ValueW-1:0] item_value;
  } hpq_req_t;

  typedef struct packed {
    logic signed [ValueW-1:0] removed_value;
    hpq_status_e              status;
    logic [CountW-1:0]        entry_count;
  } hpq_rsp_t;

endpackage

@@ rtl/hpq_mem.sv @@
// ----------------------------------------------------------------------------
// hpq_mem
// Heap storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module hpq_mem #(
  parameter int unsigned Depth = 16,
  parameter int unsigned Width = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, registered
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/max_heap_priority_queue.sv @@
// ----------------------------------------------------------------------------
// max_heap_priority_queue
// Binary max-heap priority queue held in one synchronous RAM.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; busy then stays
// high until the result strobe, and the result is on rsp_o for exactly that
// one cycle (it cannot be held off). The heap lives in a single-port-read,
// single-port-write RAM, and each heap level costs RAM reads. An insert reads
// the parent at each level, moves it down while it is smaller than the new
// value, and writes the value at the root or where it stops. An extract
// fetches the root and then the last entry; at each level that the moved
// entry sinks it reads the left child and, when one exists, the right child,
// and moves the larger child up. The entry is written at a leaf or where it
// stops above its children; an extract that empties the heap skips the
// sift-down. Refused transactions (insert when full, extract when empty)
// complete with the strobe and never raise busy.
// The entry count reported is the low 5 bits of the fill level.
module max_heap_priority_queue #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  hpq_pkg::hpq_req_t req_i,
  output logic              rsp_valid_o,
  output hpq_pkg::hpq_rsp_t rsp_o
);

  import hpq_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = AW + 2;

  hpq_state_e state_q, state_d;

  logic [CW-1:0]     cnt_q, cnt_d;
  logic [AW-1:0]     pos_q, pos_d;
  logic [ValueW-1:0] val_q, val_d;
  logic [ValueW-1:0] left_q, left_d;
  logic [ValueW-1:0] removed_q, removed_d;
  hpq_status_e       status_q, status_d;
  logic              rsp_valid_q, rsp_valid_d;

  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [ValueW-1:0] mem_wdata, mem_rdata;

  logic [AW-1:0]     parent;
  logic [XW-1:0]     lchild, rchild, cnt_x;
  logic              accept;
  logic [CW+4:0]     cnt_ext;

  hpq_mem #(
    .Depth (CAPACITY),
    .Width (ValueW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // heap index arithmetic
  assign parent = AW'((pos_q - AW'(1)) >> 1);
  assign lchild = {1'b0, pos_q, 1'b1};
  assign rchild = lchild + XW'(1);
  assign cnt_x  = XW'(cnt_q);
  assign accept = start && !busy;

  // sequencer: next state, RAM control and result
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    pos_d       = pos_q;
    val_d       = val_q;
    left_d      = left_q;
    removed_d   = removed_q;
    status_d    = status_q;
    rsp_valid_d = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = pos_q;
    mem_wdata   = val_q;
    mem_re      = 1'b0;
    mem_raddr   = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          removed_d = '0;
          status_d  = STATUS_DONE;
          if (req_i.mode == MODE_INSERT) begin
            if (cnt_q >= CW'(CAPACITY)) begin
              status_d    = STATUS_FULL;
              rsp_valid_d = 1'b1;
            end else begin
              val_d   = req_i.item_value;
              pos_d   = cnt_q[AW-1:0];
              cnt_d   = cnt_q + CW'(1);
              state_d = ST_IN_CHK;
            end
          end else begin
            if (cnt_q == '0) begin
              status_d    = STATUS_EMPTY;
              rsp_valid_d = 1'b1;
            end else begin
              cnt_d   = cnt_q - CW'(1);
              state_d = ST_EX_ROOT;
            end
          end
        end
      end

      // sift-up: the hole climbs while the parent is smaller
      ST_IN_CHK: begin
        if (pos_q == '0) begin
          mem_we      = 1'b1;
          rsp_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = parent;
          state_d   = ST_IN_CMP;
        end
      end

      ST_IN_CMP: begin
        mem_we = 1'b1;
        if ($signed(val_q) > $signed(mem_rdata)) begin
          mem_wdata = mem_rdata;
          pos_d     = parent;
          state_d   = ST_IN_CHK;
        end else begin
          rsp_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      // extract: fetch root, then the last entry
      ST_EX_ROOT: begin
        mem_re    = 1'b1;
        mem_raddr = '0;
        state_d   = ST_EX_LAST;
      end

      ST_EX_LAST: begin
        removed_d = mem_rdata;
        mem_re    = 1'b1;
        mem_raddr = cnt_q[AW-1:0];
        state_d   = ST_SD_LOAD;
      end

      ST_SD_LOAD: begin
        val_d = mem_rdata;
        pos_d = '0;
        if (cnt_q == '0) begin
          rsp_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end else begin
          state_d = ST_SD_CHK;
        end
      end

      // sift-down: the hole sinks toward the larger child
      ST_SD_CHK: begin
        if (lchild >= cnt_x) begin
          mem_we      = 1'b1;
          rsp_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = lchild[AW-1:0];
          state_d   = ST_SD_LEFT;
        end
      end

      ST_SD_LEFT: begin
        left_d = mem_rdata;
        if (rchild < cnt_x) begin
          mem_re    = 1'b1;
          mem_raddr = rchild[AW-1:0];
          state_d   = ST_SD_RIGHT;
        end else begin
          mem_we = 1'b1;
          if ($signed(mem_rdata) > $signed(val_q)) begin
            mem_wdata = mem_rdata;
            pos_d     = lchild[AW-1:0];
            state_d   = ST_SD_CHK;
          end else begin
            rsp_valid_d = 1'b1;
            state_d     = ST_IDLE;
          end
        end
      end

      ST_SD_RIGHT: begin
        mem_we = 1'b1;
        if ($signed(mem_rdata) > $signed(left_q)) begin
          // right child is the larger
          if ($signed(mem_rdata) > $signed(val_q)) begin
            mem_wdata = mem_rdata;
            pos_d     = rchild[AW-1:0];
            state_d   = ST_SD_CHK;
          end else begin
            rsp_valid_d = 1'b1;
            state_d     = ST_IDLE;
          end
        end else begin
          // left child wins, ties included
          if ($signed(left_q) > $signed(val_q)) begin
            mem_wdata = left_q;
            pos_d     = lchild[AW-1:0];
            state_d   = ST_SD_CHK;
          end else begin
            rsp_valid_d = 1'b1;
            state_d     = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      status_q    <= STATUS_DONE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      status_q    <= status_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    val_q     <= val_d;
    left_q    <= left_d;
    removed_q <= removed_d;
  end

  // outputs
  assign cnt_ext             = (CW + 5)'(cnt_q);
  assign busy                = (state_q != ST_IDLE);
  assign rsp_valid_o         = rsp_valid_q;
  assign rsp_o.removed_value = removed_q;
  assign rsp_o.status        = status_q;
  assign rsp_o.entry_count   = cnt_ext[CountW-1:0];

  // fill level never passes the capacity
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CAPACITY))
    else $error("fill level above capacity");

  // every RAM write lands inside the live heap
  a_wr_in_heap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (XW'(mem_waddr) < cnt_x))
    else $error("heap write outside live entries");

  // an accepted transaction either starts work or reports at once
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (busy || rsp_valid_o))
    else $error("accepted transaction dropped");

  // a result strobe follows work or an acceptance
  a_rsp_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> ($past(busy) || $past(start)))
    else $error("result strobe without a transaction");

  // the strobe marks the return to idle
  a_rsp_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> !busy)
    else $error("result strobe while still busy");

endmodule
